// ----- hw/rtl/gda_pkg.sv -----
// Shared types, constants and calendar helpers for the Gregorian date adder.
// Depends on nothing; used by gda_core and gregorian_date_add_days.
`default_nettype none

package gda_pkg;

    localparam int YEAR_BITS_DEF  = 16;
    localparam int COUNT_BITS_DEF = 16;

    // Request operation codes.
    localparam logic OP_SET = 1'b0;
    localparam logic OP_ADD = 1'b1;

    localparam int RESET_DAY   = 1;
    localparam int RESET_MONTH = 1;
    localparam int RESET_YEAR  = 2008;

    localparam int MONTHS      = 12;
    localparam int YEAR_CYCLE  = 400;
    localparam int RESET_YMOD  = RESET_YEAR % YEAR_CYCLE;
    localparam int CYCLE_DAYS  = 146097;
    localparam int CYCLE_BITS  = 18;
    localparam int SKIP_MARGIN = 31;
    localparam int SKIP_GUARD  = YEAR_CYCLE + 1;

    typedef struct packed {
        logic        op;
        logic [7:0]  day_in;
        logic [7:0]  month_in;
        logic [15:0] year_in;
        logic [15:0] day_count;
    } gda_req_t;

    typedef struct packed {
        logic [4:0]  day;
        logic [3:0]  month;
        logic [15:0] year;
        logic        leap;
    } gda_res_t;

    // Leap test on the year modulo 400: divisible by 4 but not a plain century.
    function automatic logic leap_of(input logic [8:0] ymod);
        return (ymod[1:0] == 2'b00) && (ymod != 9'd100) && (ymod != 9'd200)
            && (ymod != 9'd300);
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        case (month)
            4'd2:    len = leap ? 5'd29 : 5'd28;
            4'd4:    len = 5'd30;
            4'd6:    len = 5'd30;
            4'd9:    len = 5'd30;
            4'd11:   len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/gregorian_date_add_days.sv -----
// Top level of the Gregorian date adder: request and result handshakes, result register.
// Depends on gda_pkg and gda_core.
//
//   Channel   Signals                                        Direction
//   request   in_valid/in_ready, op, day_in, month_in,       in
//             year_in, day_count
//   result    out_valid/out_ready, cur_day, cur_month,       out
//             cur_year, is_leap
//
// A set request reduces the year by 400, the month by 12 and the day by the month length;
// each remainder is found by repeated subtraction on the shared subtractor.
// An add request first skips whole 400-year spans, then walks one month per cycle
// through the subtractor.
// Reset gives the date 1/1/2008. A result waits in its register while out_ready is low;
// the next request is taken meanwhile, but its result stalls until the register frees.
`default_nettype none

module gregorian_date_add_days #(
    parameter int YEAR_BITS  = gda_pkg::YEAR_BITS_DEF,
    parameter int COUNT_BITS = gda_pkg::COUNT_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        op,
    input  wire logic [7:0]  day_in,
    input  wire logic [7:0]  month_in,
    input  wire logic [15:0] year_in,
    input  wire logic [15:0] day_count,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [4:0]       cur_day,
    output logic [3:0]       cur_month,
    output logic [15:0]      cur_year,
    output logic             is_leap
);
    import gda_pkg::*;

    gda_req_t req;
    gda_res_t core_res;
    logic     core_idle, core_done, take, start;
    logic     out_valid_reg, out_valid_next;
    gda_res_t res_reg;

    assign req.op        = op;
    assign req.day_in    = day_in;
    assign req.month_in  = month_in;
    assign req.year_in   = year_in;
    assign req.day_count = day_count;

    assign in_ready = core_idle;
    assign start    = in_valid && in_ready;
    assign take     = core_done && (!out_valid_reg || out_ready);

    gda_core #(
        .YEAR_BITS  (YEAR_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .req   (req),
        .take  (take),
        .idle  (core_idle),
        .done  (core_done),
        .res   (core_res)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (take)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            res_reg <= core_res;
        end
    end

    assign out_valid = out_valid_reg;
    assign cur_day   = res_reg.day;
    assign cur_month = res_reg.month;
    assign cur_year  = res_reg.year;
    assign is_leap   = res_reg.leap;

`ifndef ASSERT_OFF
    // Once a request is taken the sequencer is busy on the following cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("request accepted while the sequencer stayed idle");

    // A finished item moves into an empty result register at once.
    a_load_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        (core_done && !out_valid_reg) |=> out_valid_reg)
        else $error("finished item not moved to the result register");

    // A delivered date always has a nonzero day and a month from 1 to 12.
    a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((cur_day != 5'd0) && (cur_month != 4'd0)
                           && (cur_month <= 4'(MONTHS))))
        else $error("result date out of range");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/gda_core.sv -----
// Date register and sequencer around one shared subtractor.
// Depends on gda_pkg; instantiated by gregorian_date_add_days.
`default_nettype none

module gda_core #(
    parameter int YEAR_BITS  = gda_pkg::YEAR_BITS_DEF,
    parameter int COUNT_BITS = gda_pkg::COUNT_BITS_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire gda_pkg::gda_req_t req,
    input  wire logic             take,
    output logic                  idle,
    output logic                  done,
    output gda_pkg::gda_res_t     res
);
    import gda_pkg::*;

    localparam int RW = (COUNT_BITS + 1 > CYCLE_BITS) ? COUNT_BITS + 1 : CYCLE_BITS;

    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_SET_YEAR  = 3'd1;
    localparam logic [2:0] ST_SET_MONTH = 3'd2;
    localparam logic [2:0] ST_SET_DAY   = 3'd3;
    localparam logic [2:0] ST_SKIP      = 3'd4;
    localparam logic [2:0] ST_WALK      = 3'd5;
    localparam logic [2:0] ST_FINISH    = 3'd6;

    logic [2:0]           state_reg, state_next;
    logic [15:0]          arg_reg, arg_next;
    logic [RW-1:0]        rem_reg, rem_next;
    logic [4:0]           day_reg, day_next;
    logic [3:0]           month_reg, month_next;
    logic [YEAR_BITS-1:0] year_reg, year_next;
    logic [8:0]           ymod_reg, ymod_next;

    logic                 cur_leap;
    logic [4:0]           cur_len;
    logic [RW-1:0]        opa, opb, diff;
    logic [RW:0]          sub_full;
    logic                 borrow;
    logic [YEAR_BITS:0]   year_chk;
    logic [YEAR_BITS-1:0] set_year;
    logic                 skip_go, walk_go;
    logic [3:0]           m_fold;
    logic [4:0]           d_fold;

    assign cur_leap = leap_of(ymod_reg);
    assign cur_len  = month_len(month_reg, cur_leap);
    assign set_year = YEAR_BITS'(req.year_in);

    // Each set field is reduced by subtracting its modulus until the remainder drops below it.
    assign opa = rem_reg;

    always_comb
    begin
        case (state_reg)
            ST_SET_YEAR:
            begin
                opb = RW'(YEAR_CYCLE);
            end
            ST_SET_MONTH:
            begin
                opb = RW'(MONTHS);
            end
            ST_SKIP:
            begin
                opb = RW'(CYCLE_DAYS);
            end
            default:
            begin
                opb = RW'(cur_len);
            end
        endcase
    end

    assign sub_full  = {1'b0, opa} - {1'b0, opb};
    assign borrow    = sub_full[RW];
    assign diff      = sub_full[RW-1:0];

    // A 400-year span may be skipped only while the year cannot wrap inside it.
    assign year_chk = {1'b0, year_reg} + (YEAR_BITS + 1)'(SKIP_GUARD);
    assign skip_go  = !borrow && (diff > RW'(SKIP_MARGIN)) && !year_chk[YEAR_BITS];
    assign walk_go  = !borrow && (diff != '0);

    assign m_fold = (rem_reg[3:0] == 4'd0) ? 4'(MONTHS) : rem_reg[3:0];
    assign d_fold = (rem_reg[4:0] == 5'd0) ? cur_len : rem_reg[4:0];

    always_comb
    begin
        state_next = state_reg;
        arg_next   = arg_reg;
        rem_next   = rem_reg;
        day_next   = day_reg;
        month_next = month_reg;
        year_next  = year_reg;
        ymod_next  = ymod_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (req.op == OP_SET)
                    begin
                        year_next  = set_year;
                        arg_next   = {req.month_in, req.day_in};
                        rem_next   = RW'(16'(set_year));
                        state_next = ST_SET_YEAR;
                    end
                    else
                    begin
                        rem_next   = RW'(day_reg) + RW'(COUNT_BITS'(req.day_count));
                        state_next = ST_SKIP;
                    end
                end
            end
            ST_SET_YEAR:
            begin
                if (!borrow)
                begin
                    rem_next = diff;
                end
                else
                begin
                    ymod_next  = rem_reg[8:0];
                    rem_next   = RW'(arg_reg[15:8]);
                    state_next = ST_SET_MONTH;
                end
            end
            ST_SET_MONTH:
            begin
                if (!borrow)
                begin
                    rem_next = diff;
                end
                else
                begin
                    month_next = m_fold;
                    rem_next   = RW'(arg_reg[7:0]);
                    state_next = ST_SET_DAY;
                end
            end
            ST_SET_DAY:
            begin
                if (!borrow)
                begin
                    rem_next = diff;
                end
                else
                begin
                    day_next   = d_fold;
                    state_next = ST_FINISH;
                end
            end
            ST_SKIP:
            begin
                if (skip_go)
                begin
                    rem_next  = diff;
                    year_next = year_reg + YEAR_BITS'(YEAR_CYCLE);
                end
                else
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (walk_go)
                begin
                    rem_next = diff;
                    if (month_reg == 4'(MONTHS))
                    begin
                        month_next = 4'd1;
                        year_next  = year_reg + YEAR_BITS'(1);
                        if ((&year_reg) || (ymod_reg == 9'(YEAR_CYCLE - 1)))
                        begin
                            ymod_next = '0;
                        end
                        else
                        begin
                            ymod_next = ymod_reg + 9'd1;
                        end
                    end
                    else
                    begin
                        month_next = month_reg + 4'd1;
                    end
                end
                else
                begin
                    day_next   = rem_reg[4:0];
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            day_reg   <= 5'(RESET_DAY);
            month_reg <= 4'(RESET_MONTH);
            year_reg  <= YEAR_BITS'(RESET_YEAR);
            ymod_reg  <= 9'(RESET_YMOD);
        end
        else
        begin
            state_reg <= state_next;
            day_reg   <= day_next;
            month_reg <= month_next;
            year_reg  <= year_next;
            ymod_reg  <= ymod_next;
        end
    end

    always_ff @(posedge clk)
    begin
        arg_reg <= arg_next;
        rem_reg <= rem_next;
    end

    assign idle       = (state_reg == ST_IDLE);
    assign done       = (state_reg == ST_FINISH);
    assign res.day    = day_reg;
    assign res.month  = month_reg;
    assign res.year   = 16'(year_reg);
    assign res.leap   = cur_leap;

endmodule

`default_nettype wire
